/* sv/mlkr_pkg.sv */
package mlkr_pkg;

   localparam int KEY_W      = 8;
   localparam int KEY_SLOTS  = 6;
   localparam int KEYS_W     = KEY_W * KEY_SLOTS;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int STREAM_W   = 16;

   localparam logic              RESET_ENABLED  = 1'b1;
   localparam logic [KEY_W-1:0]  RESET_MODIFIER = 8'd29;
   localparam logic [KEYS_W-1:0] RESET_TRIGGERS = 48'h4C4B4A484441;
   localparam logic [KEYS_W-1:0] RESET_OUTPUTS  = 48'h272628252324;

   typedef enum logic [1:0] {
      REG_ENABLED       = 2'd0,
      REG_MODIFIER_CODE = 2'd1,
      REG_TRIGGER_KEYS  = 2'd2,
      REG_OUTPUT_KEYS   = 2'd3
   } reg_index_type;

   localparam logic KIND_EVENT   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic key_down;
      logic consumed;
   } cmd_flags_type;

   typedef struct packed {
      logic             result_kind;
      logic [KEY_W-1:0] out_code;
      logic             out_down;
      logic             consumed;
      logic             last;
   } rsp_item_type;

endpackage

/* sv/mlkr_front.sv */
module mlkr_front
   import mlkr_pkg::*;
#(
   parameter int NUM_BINDINGS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic [KEY_W-1:0]        key_code,
   input  logic                    key_down,
   input  logic                    injected,
   input  logic                    enabled,
   input  logic [KEY_W-1:0]        modifier_code,
   input  logic [KEYS_W-1:0]       trigger_keys,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output logic [NUM_BINDINGS-1:0] cmd_mask,
   output cmd_flags_type           cmd_flags
);

   logic                    held_ff, held_in;
   logic [NUM_BINDINGS-1:0] active_ff, active_in;
   logic [KEY_W-1:0]        trig [NUM_BINDINGS];
   logic [NUM_BINDINGS-1:0] fire;
   logic                    accept;
   logic                    is_modifier;
   logic                    held_next;

   for (genvar i = 0; i < NUM_BINDINGS; i++) begin : g_trig
      if (i < KEY_SLOTS) begin : g_slot
         assign trig[i] = trigger_keys[KEY_W*i +: KEY_W];
      end else begin : g_none
         assign trig[i] = '0;
      end
   end

   assign in_ready    = cmd_ready;
   assign accept      = in_valid && cmd_ready;
   assign is_modifier = (key_code == modifier_code);
   assign held_next   = is_modifier ? key_down : held_ff;

   always_comb begin
      fire = '0;
      for (int i = 0; i < NUM_BINDINGS; i++) begin
         if (!injected && enabled) begin
            if (key_down) begin
               fire[i] = (trig[i] == key_code) && held_next;
            end else begin
               fire[i] = active_ff[i] && ((trig[i] == key_code) || !held_next);
            end
         end
      end
   end

   always_comb begin
      held_in   = held_ff;
      active_in = active_ff;
      if (accept && !injected) begin
         held_in = held_next;
         if (key_down) begin
            active_in = active_ff | fire;
         end else begin
            active_in = active_ff & ~fire;
         end
      end
   end

   assign cmd_valid          = accept;
   assign cmd_mask           = fire;
   assign cmd_flags.key_down = key_down;
   assign cmd_flags.consumed = !injected && ((|fire) || is_modifier);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff   <= 1'b0;
         active_ff <= '0;
      end else begin
         held_ff   <= held_in;
         active_ff <= active_in;
      end
   end

   a_press_marks_active: assert property (@(posedge clock) disable iff (reset)
      accept && key_down |=> ((active_ff & $past(fire)) == $past(fire)))
      else $error("fired binding not marked active");

   a_release_clears_active: assert property (@(posedge clock) disable iff (reset)
      accept && !key_down |=> ((active_ff & $past(fire)) == '0))
      else $error("released binding still active");

endmodule

/* sv/mlkr_queue.sv */
module mlkr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/mlkr_back.sv */
module mlkr_back
   import mlkr_pkg::*;
#(
   parameter int NUM_BINDINGS = 6
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_pop,
   input  logic [NUM_BINDINGS-1:0] cmd_mask,
   input  cmd_flags_type           cmd_flags,
   input  logic [KEYS_W-1:0]       output_keys,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output rsp_item_type            rsp_item
);

   logic                    cur_valid_ff, cur_valid_in;
   logic [NUM_BINDINGS-1:0] cur_mask_ff, cur_mask_in;
   cmd_flags_type           cur_flags_ff, cur_flags_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_item_type            rsp_item_ff, rsp_item_in;
   logic [KEY_W-1:0]        mapped [NUM_BINDINGS];
   logic [NUM_BINDINGS-1:0] low_bit;
   logic [KEY_W-1:0]        low_code;
   logic                    load_ok, emit, finish;

   for (genvar i = 0; i < NUM_BINDINGS; i++) begin : g_map
      if (i < KEY_SLOTS) begin : g_slot
         assign mapped[i] = output_keys[KEY_W*i +: KEY_W];
      end else begin : g_none
         assign mapped[i] = '0;
      end
   end

   assign low_bit = cur_mask_ff & (~cur_mask_ff + 1'b1);

   always_comb begin
      low_code = '0;
      for (int i = 0; i < NUM_BINDINGS; i++) begin
         low_code = low_code | (low_bit[i] ? mapped[i] : '0);
      end
   end

   assign load_ok = !rsp_valid_ff || rsp_ready;
   assign emit    = cur_valid_ff && load_ok;
   assign finish  = emit && (cur_mask_ff == '0);
   assign cmd_pop = !cur_valid_ff || finish;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_mask_in  = cur_mask_ff;
      cur_flags_in = cur_flags_ff;
      if (cmd_pop) begin
         cur_valid_in = cmd_valid;
         cur_mask_in  = cmd_mask;
         cur_flags_in = cmd_flags;
      end else if (emit) begin
         cur_mask_in = cur_mask_ff & ~low_bit;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (cur_mask_ff != '0) begin
            rsp_item_in.result_kind = KIND_EVENT;
            rsp_item_in.out_code    = low_code;
            rsp_item_in.out_down    = cur_flags_ff.key_down;
            rsp_item_in.consumed    = 1'b0;
            rsp_item_in.last        = 1'b0;
         end else begin
            rsp_item_in.result_kind = KIND_VERDICT;
            rsp_item_in.out_code    = '0;
            rsp_item_in.out_down    = 1'b0;
            rsp_item_in.consumed    = cur_flags_ff.consumed;
            rsp_item_in.last        = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_mask_ff  <= cur_mask_in;
      cur_flags_ff <= cur_flags_in;
      rsp_item_ff  <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   a_event_step: assert property (@(posedge clock) disable iff (reset)
      emit && (cur_mask_ff != '0) |=> cur_valid_ff &&
      ($countones(cur_mask_ff) + 1 == $countones($past(cur_mask_ff))))
      else $error("sequencer did not retire exactly one binding");

   a_kind_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_item_ff.last == (rsp_item_ff.result_kind == KIND_VERDICT)))
      else $error("last flag does not match result kind");

   a_event_not_consumed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_item_ff.result_kind == KIND_EVENT) |-> !rsp_item_ff.consumed)
      else $error("synthesized event carries consumed");

endmodule

/* sv/modifier_layer_key_remapper.sv */
// Layer-modifier key remapper. Each raw key event on the req_ stream yields zero or more
// synthesized key events followed by one verdict (tlast high, tuser high) on the rsp_
// stream. The front stage accepts one event per cycle while its two-entry command queue
// has room and updates the modifier and binding state at once; the back sequencer then
// emits one result per cycle while the output register can take it, so an event yields one
// result per fired binding plus its verdict, 1 to NUM_BINDINGS+1. The output register holds
// a result while rsp_tready is low and reloads in the cycle the held one is taken. The
// registers must be written over the csr_ port only while idle; the user is bound, the block does not enforce it.
module modifier_layer_key_remapper
   import mlkr_pkg::*;
#(
   parameter int NUM_BINDINGS = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [STREAM_W-1:0]   req_tdata,  // key_code, key_down
   input  logic                  req_tuser,  // injected
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STREAM_W-1:0]   rsp_tdata,  // out_code, out_down, consumed
   output logic                  rsp_tuser,  // result_kind
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CMD_W = NUM_BINDINGS + $bits(cmd_flags_type);

   logic              enabled_ff, enabled_in;
   logic [KEY_W-1:0]  modifier_code_ff, modifier_code_in;
   logic [KEYS_W-1:0] trigger_keys_ff, trigger_keys_in;
   logic [KEYS_W-1:0] output_keys_ff, output_keys_in;
   reg_index_type     csr_index;
   logic              csr_write;

   logic                    front_valid, front_ready;
   logic [NUM_BINDINGS-1:0] front_mask;
   cmd_flags_type           front_flags;
   logic                    q_valid, q_pop;
   logic [CMD_W-1:0]        q_data;
   logic [NUM_BINDINGS-1:0] q_mask;
   cmd_flags_type           q_flags;
   rsp_item_type            rsp_item;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_comb begin
      enabled_in       = enabled_ff;
      modifier_code_in = modifier_code_ff;
      trigger_keys_in  = trigger_keys_ff;
      output_keys_in   = output_keys_ff;
      if (csr_write) begin
         case (csr_index)
            REG_ENABLED:       enabled_in       = csr_pwdata[0];
            REG_MODIFIER_CODE: modifier_code_in = csr_pwdata[KEY_W-1:0];
            REG_TRIGGER_KEYS:  trigger_keys_in  = csr_pwdata[KEYS_W-1:0];
            REG_OUTPUT_KEYS:   output_keys_in   = csr_pwdata[KEYS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_ENABLED:       csr_prdata = CSR_DATA_W'(enabled_ff);
         REG_MODIFIER_CODE: csr_prdata = CSR_DATA_W'(modifier_code_ff);
         REG_TRIGGER_KEYS:  csr_prdata = CSR_DATA_W'(trigger_keys_ff);
         REG_OUTPUT_KEYS:   csr_prdata = CSR_DATA_W'(output_keys_ff);
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff       <= RESET_ENABLED;
         modifier_code_ff <= RESET_MODIFIER;
         trigger_keys_ff  <= RESET_TRIGGERS;
         output_keys_ff   <= RESET_OUTPUTS;
      end else begin
         enabled_ff       <= enabled_in;
         modifier_code_ff <= modifier_code_in;
         trigger_keys_ff  <= trigger_keys_in;
         output_keys_ff   <= output_keys_in;
      end
   end

   mlkr_front #(
      .NUM_BINDINGS (NUM_BINDINGS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .key_code      (req_tdata[KEY_W-1:0]),
      .key_down      (req_tdata[KEY_W]),
      .injected      (req_tuser),
      .enabled       (enabled_ff),
      .modifier_code (modifier_code_ff),
      .trigger_keys  (trigger_keys_ff),
      .cmd_valid     (front_valid),
      .cmd_ready     (front_ready),
      .cmd_mask      (front_mask),
      .cmd_flags     (front_flags)
   );

   mlkr_queue #(
      .WIDTH (CMD_W),
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_valid),
      .push_ready (front_ready),
      .push_data  ({front_mask, front_flags}),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_data)
   );

   assign q_mask  = q_data[CMD_W-1 -: NUM_BINDINGS];
   assign q_flags = cmd_flags_type'(q_data[$bits(cmd_flags_type)-1:0]);

   mlkr_back #(
      .NUM_BINDINGS (NUM_BINDINGS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_valid),
      .cmd_pop     (q_pop),
      .cmd_mask    (q_mask),
      .cmd_flags   (q_flags),
      .output_keys (output_keys_ff),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_item    (rsp_item)
   );

   assign rsp_tdata = STREAM_W'({rsp_item.consumed, rsp_item.out_down, rsp_item.out_code});
   assign rsp_tuser = rsp_item.result_kind;
   assign rsp_tlast = rsp_item.last;

endmodule

/* sim/tb_modifier_layer_key_remapper.sv */
module tb_modifier_layer_key_remapper;
   import mlkr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 12;

   logic                  clock;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [STREAM_W-1:0]   req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [STREAM_W-1:0]   rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // layer state and register copies
   logic              layer_enabled  = RESET_ENABLED;
   logic [KEY_W-1:0]  layer_modifier = RESET_MODIFIER;
   logic [KEYS_W-1:0] layer_triggers = RESET_TRIGGERS;
   logic [KEYS_W-1:0] layer_outputs  = RESET_OUTPUTS;
   logic              modifier_down  = 1'b0;
   logic [KEY_SLOTS-1:0] binding_live = '0;

   rsp_item_type key_results_due[$];
   int           mismatches  = 0;
   int           items_sent  = 0;
   int           idle_cycles = 0;
   int           rsp_hold    = 0;
   bit           rush        = 1'b0;

   modifier_layer_key_remapper u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic rsp_item_type make_result(logic kind, logic [KEY_W-1:0] code,
                                                logic down, logic cons, logic fin);
      rsp_item_type r;
      r.result_kind = kind;
      r.out_code    = code;
      r.out_down    = down;
      r.consumed    = cons;
      r.last        = fin;
      return r;
   endfunction

   function automatic void remap_key_event(logic [KEY_W-1:0] code, logic down, logic inj);
      logic             swallow;
      logic [KEY_W-1:0] trig;
      logic [KEY_W-1:0] mapped;
      swallow = 1'b0;
      if (inj) begin
         key_results_due.push_back(make_result(KIND_VERDICT, '0, 1'b0, 1'b0, 1'b1));
         return;
      end
      if (code == layer_modifier)
         modifier_down = down;
      if (layer_enabled) begin
         for (int i = 0; i < KEY_SLOTS; i++) begin
            trig   = layer_triggers[i*KEY_W +: KEY_W];
            mapped = layer_outputs[i*KEY_W +: KEY_W];
            if (down) begin
               if (trig == code && modifier_down) begin
                  key_results_due.push_back(make_result(KIND_EVENT, mapped, 1'b1, 1'b0, 1'b0));
                  binding_live[i] = 1'b1;
                  swallow = 1'b1;
               end
            end else if (binding_live[i] && (trig == code || !modifier_down)) begin
               key_results_due.push_back(make_result(KIND_EVENT, mapped, 1'b0, 1'b0, 1'b0));
               binding_live[i] = 1'b0;
               swallow = 1'b1;
            end
         end
      end
      if (code == layer_modifier)
         swallow = 1'b1;
      key_results_due.push_back(make_result(KIND_VERDICT, '0, 1'b0, swallow, 1'b1));
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_hold = 0;
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (key_results_due.size() == 0) begin
               $error("unexpected result: kind %0h code %0h", rsp_tuser, rsp_tdata[7:0]);
               mismatches++;
            end else begin
               want = key_results_due.pop_front();
               if (rsp_tuser !== want.result_kind) begin
                  $error("result_kind expected %0h actual %0h", want.result_kind, rsp_tuser);
                  mismatches++;
               end
               if (rsp_tdata[7:0] !== want.out_code) begin
                  $error("out_code expected %0h actual %0h", want.out_code, rsp_tdata[7:0]);
                  mismatches++;
               end
               if (rsp_tdata[8] !== want.out_down) begin
                  $error("out_down expected %0h actual %0h", want.out_down, rsp_tdata[8]);
                  mismatches++;
               end
               if (rsp_tdata[9] !== want.consumed) begin
                  $error("consumed expected %0h actual %0h", want.consumed, rsp_tdata[9]);
                  mismatches++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last expected %0h actual %0h", want.last, rsp_tlast);
                  mismatches++;
               end
            end
            rsp_hold = rush ? 0 : $urandom_range(0, 18);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_tready <= (rsp_hold == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_key_event(logic [KEY_W-1:0] code, logic down, logic inj);
      int gap;
      gap = rush ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, down, code};
      req_tuser  <= inj;
      do @(posedge clock); while (!req_tready);
      remap_key_event(code, down, inj);
      items_sent++;
   endtask

   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (key_results_due.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      wait_quiet();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ENABLED:       layer_enabled  = value[0];
         REG_MODIFIER_CODE: layer_modifier = value[KEY_W-1:0];
         REG_TRIGGER_KEYS:  layer_triggers = value[KEYS_W-1:0];
         REG_OUTPUT_KEYS:   layer_outputs  = value[KEYS_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic [KEY_W-1:0] pick_trigger();
      return layer_triggers[$urandom_range(0, KEY_SLOTS-1)*KEY_W +: KEY_W];
   endfunction

   task automatic test_default_layer();
      send_key_event(RESET_MODIFIER, 1'b1, 1'b0);
      send_key_event(8'h41, 1'b1, 1'b0);
      send_key_event(8'h41, 1'b0, 1'b0);
      send_key_event(8'h48, 1'b1, 1'b0);
      send_key_event(RESET_MODIFIER, 1'b0, 1'b0);
   endtask

   task automatic test_injected_passthrough();
      send_key_event(RESET_MODIFIER, 1'b1, 1'b1);
      send_key_event(RESET_MODIFIER, 1'b1, 1'b0);
      send_key_event(8'h4C, 1'b1, 1'b1);
      send_key_event(RESET_MODIFIER, 1'b0, 1'b0);
   endtask

   task automatic test_code_extremes();
      send_key_event(8'h00, 1'b1, 1'b0);
      send_key_event(8'h00, 1'b0, 1'b0);
      send_key_event(8'hFF, 1'b1, 1'b0);
      send_key_event(8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_disabled_layer();
      send_key_event(RESET_MODIFIER, 1'b1, 1'b0);
      send_key_event(8'h44, 1'b1, 1'b0);
      csr_write(REG_ENABLED, '0);
      send_key_event(8'h4A, 1'b1, 1'b0);
      send_key_event(8'h44, 1'b0, 1'b0);
      send_key_event(RESET_MODIFIER, 1'b0, 1'b0);
      csr_write(REG_ENABLED, 64'd1);
      send_key_event(8'h4B, 1'b0, 1'b0);
   endtask

   // modifier doubles as the shared trigger of all six bindings
   task automatic test_shared_triggers();
      csr_write(REG_MODIFIER_CODE, '0);
      csr_write(REG_TRIGGER_KEYS, '0);
      csr_write(REG_OUTPUT_KEYS, {16'd0, {KEYS_W{1'b1}}});
      send_key_event(8'h00, 1'b1, 1'b0);
      send_key_event(8'h00, 1'b0, 1'b0);
      csr_write(REG_MODIFIER_CODE, 64'hFF);
      csr_write(REG_TRIGGER_KEYS, {16'd0, {KEYS_W{1'b1}}});
      csr_write(REG_OUTPUT_KEYS, '0);
      send_key_event(8'hFF, 1'b1, 1'b0);
      send_key_event(8'hFF, 1'b0, 1'b0);
   endtask

   task automatic play_chord();
      int               presses;
      logic [KEY_W-1:0] k;
      if ($urandom_range(0, 7) != 0)
         send_key_event(layer_modifier, 1'b1, 1'b0);
      presses = $urandom_range(1, 4);
      repeat (presses) begin
         k = pick_trigger();
         send_key_event(k, 1'b1, 1'b0);
         if ($urandom_range(0, 1))
            send_key_event(k, 1'b0, 1'b0);
      end
      if ($urandom_range(0, 3) == 0)
         send_key_event(pick_trigger(), 1'($urandom_range(0, 1)), 1'b1);
      send_key_event(layer_modifier, 1'b0, 1'b0);
      if ($urandom_range(0, 1))
         send_key_event(pick_trigger(), 1'b0, 1'b0);
   endtask

   task automatic test_random_layers();
      logic [KEY_W-1:0]  pool[4];
      logic [KEYS_W-1:0] trigs;
      int                goal;
      for (int phase = 0; phase < 6; phase++) begin
         rush = (phase == 2);
         csr_write(REG_MODIFIER_CODE, 64'($urandom_range(0, 255)));
         pool[0] = layer_modifier;
         for (int i = 1; i < 4; i++)
            pool[i] = KEY_W'($urandom_range(0, 255));
         for (int i = 0; i < KEY_SLOTS; i++)
            trigs[i*KEY_W +: KEY_W] = ($urandom_range(0, 5) == 0) ?
                                      KEY_W'($urandom_range(0, 255)) :
                                      pool[$urandom_range(0, 3)];
         csr_write(REG_TRIGGER_KEYS, 64'(trigs));
         csr_write(REG_OUTPUT_KEYS, {16'd0, 16'($urandom_range(0, 65535)), 32'($urandom)});
         csr_write(REG_ENABLED, 64'(phase != 4));
         goal = items_sent + 70;
         while (items_sent < goal) begin
            if ($urandom_range(0, 4) == 0)
               send_key_event(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 7) == 0);
            else
               play_chord();
            if ($urandom_range(0, 11) == 0)
               csr_write(REG_ENABLED, 64'(!layer_enabled));
            if (phase == 3 && $urandom_range(0, 5) == 0)
               wait_quiet();
         end
      end
      rush = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_layer();
      test_injected_passthrough();
      test_code_extremes();
      test_disabled_layer();
      test_shared_triggers();
      test_random_layers();
      wait_quiet();
      if (mismatches == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
